>>> rtl/sis_pkg.sv
// sis_pkg: shared constants, record type and sequencer states of the stable insertion sorter
`default_nettype none
package sis_pkg;

  localparam int unsigned MaxNodes = 32;
  localparam int unsigned AddrW    = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int unsigned CountW   = $clog2(MaxNodes + 1);
  localparam int unsigned KeyW     = 16;
  localparam int unsigned TagW     = 8;
  localparam int unsigned RecW     = KeyW + TagW;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } sis_rec_t;

  typedef enum logic [2:0] {
    SIdle,
    SRead,
    SWrite,
    SEmitRd,
    SEmitLd,
    SEmitOut
  } sis_state_e;

endpackage
`default_nettype wire

>>> rtl/sis_ram.sv
// sis_ram: generic single write port, single read port ram with registered read
`default_nettype none
module sis_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire  logic                            clk_i,
  input  wire  logic                            we_i,
  input  wire  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  wire  logic [Width-1:0]                wdata_i,
  input  wire  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic       [Width-1:0]                rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/stable_insertion_sorter_unit.sv
// stable_insertion_sorter_unit: sequenced stable insertion sort over a record ram
//
// Input channel (in_valid_i / in_ready_o) takes one record per transfer: a
// 16-bit order key, an 8-bit tag and a last mark. Records are kept in key
// order in a MaxNodes-entry ram; equal keys keep their arrival order.
// Inserting a record walks the stored entries from the top through a single
// compare-and-shift step, one entry per cycle, sharing the ram's one read and
// one write port, and in_ready_o is low meanwhile.
// A record that meets a full store is dropped and sets the overflow flag.
// A record marked last is stored first (or dropped on a full store), then the
// whole store is sent on the output channel (out_valid_o / out_ready_i) in
// ascending key order via a registered ram read and an output register, one
// at a time, the final one with last_out_o high, each carrying overflowed_o.
// A stalled receiver simply holds the output register; no input is taken
// until the run ends, after which the count and the flag are clear.
// Reset empties the store (count zero, flag clear) with no clearing pass.
`default_nettype none
module stable_insertion_sorter_unit
  import sis_pkg::*;
(
  input  wire  logic            clk_i,
  input  wire  logic            rst_ni,
  input  wire  logic            in_valid_i,
  output logic                  in_ready_o,
  input  wire  logic [KeyW-1:0] order_key_i,
  input  wire  logic [TagW-1:0] record_tag_i,
  input  wire  logic            last_item_i,
  output logic                  out_valid_o,
  input  wire  logic            out_ready_i,
  output logic       [KeyW-1:0] sorted_key_o,
  output logic       [TagW-1:0] sorted_tag_o,
  output logic                  overflowed_o,
  output logic                  last_out_o
);

  localparam logic [CountW-1:0] FullCount = CountW'(MaxNodes);
  localparam logic [CountW-1:0] One       = CountW'(1);
  localparam logic [CountW-1:0] Two       = CountW'(2);

  sis_state_e state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] pos_q, pos_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic              ovf_q, ovf_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [TagW-1:0]   tag_q, tag_d;
  logic              last_q, last_d;

  logic [KeyW-1:0]   out_key_q, out_key_d;
  logic [TagW-1:0]   out_tag_q, out_tag_d;
  logic              out_ovf_q, out_ovf_d;
  logic              out_last_q, out_last_d;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [RecW-1:0]   ram_wdata;
  logic [AddrW-1:0]  ram_raddr;
  logic [RecW-1:0]   ram_rdata;
  sis_rec_t          rd_rec;
  sis_rec_t          new_rec;
  logic [CountW-1:0] pos_m1, pos_m2, count_m1;

  sis_ram #(
    .Width(RecW),
    .Depth(MaxNodes)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_rec   = sis_rec_t'(ram_rdata);
  assign new_rec  = '{key: key_q, tag: tag_q};
  assign pos_m1   = pos_q - One;
  assign pos_m2   = pos_q - Two;
  assign count_m1 = count_q - One;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    idx_q      <= idx_d;
    key_q      <= key_d;
    tag_q      <= tag_d;
    last_q     <= last_d;
    out_key_q  <= out_key_d;
    out_tag_q  <= out_tag_d;
    out_ovf_q  <= out_ovf_d;
    out_last_q <= out_last_d;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    pos_d      = pos_q;
    idx_d      = idx_q;
    key_d      = key_q;
    tag_d      = tag_q;
    last_d     = last_q;
    out_key_d  = out_key_q;
    out_tag_d  = out_tag_q;
    out_ovf_d  = out_ovf_q;
    out_last_d = out_last_q;
    ram_we     = 1'b0;
    ram_waddr  = pos_q[AddrW-1:0];
    ram_wdata  = ram_rdata;
    ram_raddr  = pos_m2[AddrW-1:0];
    in_ready_o = 1'b0;

    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        ram_raddr  = count_m1[AddrW-1:0];
        if (in_valid_i) begin
          key_d  = order_key_i;
          tag_d  = record_tag_i;
          last_d = last_item_i;
          idx_d  = '0;
          pos_d  = count_q;
          if (count_q >= FullCount) begin
            // store full: drop the record
            ovf_d   = 1'b1;
            state_d = last_item_i ? SEmitRd : SIdle;
          end else if (count_q == '0) begin
            state_d = SWrite;
          end else begin
            state_d = SRead;
          end
        end
      end
      SRead: begin
        // entry at pos - 1 is on the read port
        if (rd_rec.key > key_q) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_d     = pos_m1;
          state_d   = (pos_q == One) ? SWrite : SRead;
        end else begin
          state_d = SWrite;
        end
      end
      SWrite: begin
        ram_we    = 1'b1;
        ram_wdata = new_rec;
        count_d   = count_q + One;
        state_d   = last_q ? SEmitRd : SIdle;
      end
      SEmitRd: begin
        ram_raddr = idx_q[AddrW-1:0];
        state_d   = SEmitLd;
      end
      SEmitLd: begin
        out_key_d  = rd_rec.key;
        out_tag_d  = rd_rec.tag;
        out_ovf_d  = ovf_q;
        out_last_d = (idx_q == count_m1);
        state_d    = SEmitOut;
      end
      SEmitOut: begin
        if (out_ready_i) begin
          if (out_last_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = SIdle;
          end else begin
            idx_d   = idx_q + One;
            state_d = SEmitRd;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign out_valid_o  = (state_q == SEmitOut);
  assign sorted_key_o = out_key_q;
  assign sorted_tag_o = out_tag_q;
  assign overflowed_o = out_ovf_q;
  assign last_out_o   = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("record count above store size");

  a_ready_valid_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready during emission");

  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_out_o) |=> (count_q == '0 && !ovf_q))
    else $error("count or flag not cleared after final transfer");

  a_shift_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SRead) |-> (pos_q != '0 && pos_q <= count_q))
    else $error("shift position out of range");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEmitRd) |-> (count_q != '0 && idx_q < count_q))
    else $error("emission index out of range");

endmodule
`default_nettype wire

>>> tb/sv/stable_insertion_sorter_unit_tb.sv
// stable_insertion_sorter_unit_tb: self-checking testbench for the stable insertion sorter
`timescale 1ns / 1ps
module stable_insertion_sorter_unit_tb;
  import sis_pkg::*;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
    logic            ovf;
    logic            last;
  } sorted_rec_t;

  typedef enum int {
    KeyWide,
    KeyNarrow,
    KeyEdge
  } key_mode_e;

  class sort_scoreboard;
    sis_rec_t    held [MaxNodes];
    int unsigned held_count;
    bit          dropped_any;
    sorted_rec_t sorted_q [$];
    int unsigned errors;
    int unsigned sets_done;
    int unsigned drops;
    int unsigned results_seen;

    // keeps the held records in key order, equal keys in arrival order
    function void insert_record(logic [KeyW-1:0] key, logic [TagW-1:0] tag, logic last);
      int unsigned pos;
      sorted_rec_t exp_rec;
      if (held_count >= MaxNodes) begin
        dropped_any = 1'b1;
        drops++;
      end else begin
        pos = held_count;
        while (pos > 0 && held[pos-1].key > key) begin
          held[pos] = held[pos-1];
          pos--;
        end
        held[pos].key = key;
        held[pos].tag = tag;
        held_count++;
      end
      if (last) begin
        for (int unsigned k = 0; k < held_count; k++) begin
          exp_rec.key  = held[k].key;
          exp_rec.tag  = held[k].tag;
          exp_rec.ovf  = dropped_any;
          exp_rec.last = (k + 1 == held_count);
          sorted_q.push_back(exp_rec);
        end
        held_count  = 0;
        dropped_any = 1'b0;
        sets_done++;
      end
    endfunction

    function void check_result(logic [KeyW-1:0] key, logic [TagW-1:0] tag, logic ovf,
                               logic last);
      sorted_rec_t exp_rec;
      results_seen++;
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected sorted record key=%0h tag=%0h ovf=%0b last=%0b",
                 $time, key, tag, ovf, last);
        errors++;
        return;
      end
      exp_rec = sorted_q.pop_front();
      if (key !== exp_rec.key) begin
        $display("%0t: sorted_key expected %0h actual %0h", $time, exp_rec.key, key);
        errors++;
      end
      if (tag !== exp_rec.tag) begin
        $display("%0t: sorted_tag expected %0h actual %0h", $time, exp_rec.tag, tag);
        errors++;
      end
      if (ovf !== exp_rec.ovf) begin
        $display("%0t: overflowed expected %0b actual %0b", $time, exp_rec.ovf, ovf);
        errors++;
      end
      if (last !== exp_rec.last) begin
        $display("%0t: last_out expected %0b actual %0b", $time, exp_rec.last, last);
        errors++;
      end
    endfunction
  endclass

  logic            clk_i        = 1'b0;
  logic            rst_ni       = 1'b0;
  logic            in_valid_i   = 1'b0;
  logic            in_ready_o;
  logic [KeyW-1:0] order_key_i  = '0;
  logic [TagW-1:0] record_tag_i = '0;
  logic            last_item_i  = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i  = 1'b1;
  logic [KeyW-1:0] sorted_key_o;
  logic [TagW-1:0] sorted_tag_o;
  logic            overflowed_o;
  logic            last_out_o;

  sort_scoreboard sb = new();
  bit             quiet = 1'b0;
  int unsigned    records_sent = 0;

  stable_insertion_sorter_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .order_key_i  (order_key_i),
    .record_tag_i (record_tag_i),
    .last_item_i  (last_item_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sorted_key_o (sorted_key_o),
    .sorted_tag_o (sorted_tag_o),
    .overflowed_o (overflowed_o),
    .last_out_o   (last_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_record(input logic [KeyW-1:0] key, input logic [TagW-1:0] tag,
                             input logic last);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    order_key_i  <= key;
    record_tag_i <= tag;
    last_item_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.insert_record(key, tag, last);
    records_sent++;
  endtask

  function automatic logic [KeyW-1:0] pick_key(key_mode_e mode);
    case (mode)
      KeyNarrow: return KeyW'($urandom_range(0, 3));
      KeyEdge: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return '1;
          default: return KeyW'($urandom);
        endcase
      end
      default: return KeyW'($urandom);
    endcase
  endfunction

  task automatic send_set(input int unsigned len, input key_mode_e mode);
    for (int unsigned i = 0; i < len; i++) begin
      send_record(pick_key(mode), TagW'($urandom), i == len - 1);
    end
  endtask

  // receiver side: check each output transfer, stall in short bursts
  initial begin : drain
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        sb.check_result(sorted_key_o, sorted_tag_o, overflowed_o, last_out_o);
      end
      if (stall_left == 0 && !quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned set_idx;
    int unsigned set_len;
    int unsigned pick;
    key_mode_e   mode;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest sets, extreme keys and tags
    send_record(16'h0000, 8'h00, 1'b1);
    send_record(16'hffff, 8'hff, 1'b1);
    // equal keys must keep arrival order
    send_record(16'd5, 8'd1, 1'b0);
    send_record(16'd5, 8'd2, 1'b0);
    send_record(16'd3, 8'd3, 1'b0);
    send_record(16'hffff, 8'd4, 1'b0);
    send_record(16'h0000, 8'd5, 1'b0);
    send_record(16'd5, 8'd6, 1'b1);
    // descending keys walk the whole store each time
    send_record(16'd40, 8'h81, 1'b0);
    send_record(16'd30, 8'h42, 1'b0);
    send_record(16'd20, 8'h24, 1'b0);
    send_record(16'd10, 8'h18, 1'b1);
    // ascending keys land on top without a walk
    send_record(16'd1, 8'h7e, 1'b0);
    send_record(16'd2, 8'hbd, 1'b0);
    send_record(16'h8000, 8'hdb, 1'b1);

    set_idx = 0;
    while (records_sent < 370) begin
      if (records_sent >= 300) quiet = 1'b1;
      pick = $urandom_range(0, 9);
      if (set_idx == 0) begin
        set_len = MaxNodes;          // exactly full
      end else if (set_idx == 1) begin
        set_len = MaxNodes + 2;      // overflow, the last record is dropped too
      end else if (pick <= 6) begin
        set_len = $urandom_range(1, 6);
      end else if (pick == 7) begin
        set_len = $urandom_range(7, 20);
      end else if (pick == 8) begin
        set_len = $urandom_range(MaxNodes - 4, MaxNodes + 1);
      end else begin
        set_len = $urandom_range(MaxNodes + 2, MaxNodes + 8);
      end
      case ($urandom_range(0, 2))
        0: mode = KeyNarrow;
        1: mode = KeyEdge;
        default: mode = KeyWide;
      endcase
      send_set(set_len, mode);
      set_idx++;
    end
    in_valid_i <= 1'b0;

    while (sb.sorted_q.size() != 0) @(posedge clk_i);
    repeat (MaxNodes + 8) @(posedge clk_i);

    $display("ran %0d sets with %0d records, %0d of them dropped on a full store",
             sb.sets_done, records_sent, sb.drops);
    $display("checked %0d sorted output transfers, %0d mismatches",
             sb.results_seen, sb.errors);
    if (sb.errors == 0 && sb.sorted_q.size() == 0) begin
      $display("stable_insertion_sorter_unit_tb: clean");
    end else begin
      $display("stable_insertion_sorter_unit_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d sorted records still awaited", sb.sorted_q.size());
    $display("stable_insertion_sorter_unit_tb: errors");
    $finish;
  end

endmodule
